FILE: src/lge_pkg.sv
package lge_pkg;

  localparam int DEF_GRID_WIDTH  = 32;
  localparam int DEF_GRID_HEIGHT = 32;

  // B3/S23 neighbor counts.
  localparam int BIRTH_N   = 3;
  localparam int SURVIVE_N = 2;

  localparam logic [10:0] POP_MAX = 11'd2047;
  localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_STEP   = 2'd0,
    REQ_TOGGLE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef struct packed {
    req_e       req_type;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
  } req_t;

  typedef struct packed {
    logic        cell_alive;
    logic [10:0] population;
    logic [31:0] generation_count;
    logic        stable;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SHIFT,
    ST_SWEEP,
    ST_COMMIT,
    ST_CRD,
    ST_CEXE,
    ST_RESP
  } lge_state_e;

  // Control from the sequencer to the grid memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_alt;   // write into the bank that is not the live grid
    logic mark;     // mark the written row of the live grid valid
    logic clr_all;  // forget every row of the live grid
    logic commit;   // make the other bank the live grid, all rows valid
  } mem_ctrl_t;

endpackage

FILE: src/lge_stream_if.sv
interface lge_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/lge_rule.sv
module lge_rule (
  input  logic [7:0] nbr,
  input  logic       center,
  output logic       next_alive
);
  import lge_pkg::*;

  logic [3:0] cnt;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + 4'(nbr[i]);
    end
  end

  // A dead cell with two neighbors stays dead.
  assign next_alive = (cnt == 4'(BIRTH_N)) || (center && (cnt == 4'(SURVIVE_N)));

endmodule

FILE: src/lge_grid_mem.sv
module lge_grid_mem #(
  parameter int GRID_WIDTH  = lge_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = lge_pkg::DEF_GRID_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lge_pkg::mem_ctrl_t             ctrl,
  input  logic [$clog2(GRID_HEIGHT)-1:0] rd_row,
  input  logic [$clog2(GRID_HEIGHT)-1:0] wr_row,
  input  logic [GRID_WIDTH-1:0]          wr_data,
  output logic [GRID_WIDTH-1:0]          rd_data
);
  import lge_pkg::*;

  // Two banks of rows: the live grid and the one the next generation is built in.
  logic [GRID_WIDTH-1:0]  bank_mem [2][GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] valid_r;
  logic                   bank_r;
  logic [GRID_WIDTH-1:0]  rd_q_r;
  logic                   rd_valid_r;
  logic                   wr_bank;

  assign wr_bank = ctrl.wr_alt ? ~bank_r : bank_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      bank_mem[wr_bank][wr_row] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q_r     <= bank_mem[bank_r][rd_row];
      rd_valid_r <= valid_r[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      bank_r  <= 1'b0;
    end else begin
      priority if (ctrl.clr_all) begin
        valid_r <= '0;
      end else if (ctrl.commit) begin
        valid_r <= '1;
        bank_r  <= ~bank_r;
      end else if (ctrl.wr_en && ctrl.mark) begin
        valid_r[wr_row] <= 1'b1;
      end
    end
  end

  // A row never written since the last clear reads as all dead.
  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule

FILE: src/life_generation_engine.sv
// Channel   Direction  Payload
// in_req    sink       req_type, cell_x, cell_y
// out_rsp   source     cell_alive, population, generation_count, stable
//
// A step sweeps one cell per cycle through the shared rule unit, with a fetch and a
// shift per row from the grid memory, which has one read port and one write port.
// Toggle, clear and read pass through the ST_CRD, ST_CEXE and ST_RESP states.
// in_req is ready again in the cycle after the result is loaded; a finished result waits in
// the output register while the next request runs, and a second one holds the block.
// Reset clears per-row valid bits at once, so no clearing pass is needed.
module life_generation_engine #(
  parameter int GRID_WIDTH  = lge_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = lge_pkg::DEF_GRID_HEIGHT
) (
  input logic          clk,
  input logic          rst_n,
  lge_stream_if.sink   in_req,
  lge_stream_if.source out_rsp
);
  import lge_pkg::*;

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);
  localparam int FW = $clog2(GRID_HEIGHT + 1);
  localparam int PW = $clog2(GRID_WIDTH * GRID_HEIGHT + 1);

  lge_state_e            state_r, state_nxt;
  req_t                  req_r;
  logic [FW-1:0]         fetch_r;
  logic [XW-1:0]         x_r;
  logic [GRID_WIDTH-1:0] up_r, mid_r, dn_r, nrow_r;
  logic [2:0]            lft_r;
  logic                  diff_r;
  logic [PW-1:0]         acc_r, pop_r;
  logic [31:0]           gen_r;
  logic                  stable_r, alive_r, out_valid_r;
  rsp_t                  rsp_r;

  mem_ctrl_t             mem_ctrl;
  logic [RW-1:0]         rd_row, wr_row;
  logic [GRID_WIDTH-1:0] wr_data, rd_data;

  logic          in_acc, slot_free, x_last, fetch_in, fetch_end, in_grid;
  logic          r_en, next_bit, cur_bit;
  logic [FW-1:0] row_m1;
  logic [XW-1:0] xi;
  logic [RW-1:0] yi;
  logic [7:0]    nbr;
  logic [10:0]   pop_sat;

  assign in_acc    = in_req.valid && in_req.ready;
  assign slot_free = !out_valid_r || out_rsp.ready;
  assign x_last    = (x_r == XW'(GRID_WIDTH - 1));
  assign fetch_in  = (fetch_r < FW'(GRID_HEIGHT));
  assign fetch_end = (fetch_r == FW'(GRID_HEIGHT));
  assign row_m1    = fetch_r - FW'(1);
  assign xi        = XW'(req_r.cell_x);
  assign yi        = RW'(req_r.cell_y);
  assign in_grid   = (int'(req_r.cell_x) < GRID_WIDTH) && (int'(req_r.cell_y) < GRID_HEIGHT);
  assign cur_bit   = rd_data[xi];
  assign pop_sat   = (32'(pop_r) > 32'(POP_MAX)) ? POP_MAX : 11'(pop_r);

  // The rows rotate right during a sweep, so bit 0 is the current column and the
  // left column is held in lft_r; the right column is outside on the last cell.
  assign r_en = !x_last;
  assign nbr  = {lft_r[2], up_r[0], up_r[1] & r_en,
                 lft_r[1],          mid_r[1] & r_en,
                 lft_r[0], dn_r[0], dn_r[1] & r_en};

  lge_rule u_rule (
    .nbr        (nbr),
    .center     (mid_r[0]),
    .next_alive (next_bit)
  );

  lge_grid_mem #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_grid_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mem_ctrl),
    .rd_row  (rd_row),
    .wr_row  (wr_row),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req.data.req_type)
            REQ_STEP:   state_nxt = ST_FETCH;
            REQ_TOGGLE: state_nxt = ST_CRD;
            REQ_CLEAR:  state_nxt = ST_CRD;
            REQ_READ:   state_nxt = ST_CRD;
            default:    state_nxt = ST_CRD;
          endcase
        end
      end
      ST_FETCH:  state_nxt = ST_SHIFT;
      ST_SHIFT:  state_nxt = (fetch_r == '0) ? ST_FETCH : ST_SWEEP;
      ST_SWEEP: begin
        if (x_last) begin
          state_nxt = fetch_end ? ST_COMMIT : ST_FETCH;
        end
      end
      ST_COMMIT: state_nxt = ST_CRD;
      ST_CRD:    state_nxt = ST_CEXE;
      ST_CEXE:   state_nxt = ST_RESP;
      ST_RESP: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_req.ready = (state_r == ST_IDLE);
    mem_ctrl     = '0;
    rd_row       = yi;
    wr_row       = yi;
    wr_data      = rd_data ^ (GRID_WIDTH'(1) << xi);
    unique case (state_r)
      ST_IDLE: begin
        mem_ctrl.clr_all = in_acc && (in_req.data.req_type == REQ_CLEAR);
      end
      ST_FETCH: begin
        mem_ctrl.rd_en = fetch_in;
        rd_row         = fetch_r[RW-1:0];
      end
      ST_SWEEP: begin
        mem_ctrl.wr_en  = x_last;
        mem_ctrl.wr_alt = 1'b1;
        wr_row          = row_m1[RW-1:0];
        wr_data         = {next_bit, nrow_r[GRID_WIDTH-1:1]};
      end
      ST_COMMIT: begin
        mem_ctrl.commit = diff_r;
      end
      ST_CRD: begin
        mem_ctrl.rd_en = 1'b1;
      end
      ST_CEXE: begin
        mem_ctrl.wr_en = (req_r.req_type == REQ_TOGGLE) && in_grid;
        mem_ctrl.mark  = 1'b1;
      end
      ST_SHIFT, ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pop_r   <= '0;
      gen_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_req.data.req_type == REQ_CLEAR)) begin
            pop_r <= '0;
            gen_r <= '0;
          end
        end
        ST_COMMIT: begin
          if (diff_r) begin
            pop_r <= acc_r;
            if (gen_r != GEN_MAX) begin
              gen_r <= gen_r + 32'd1;
            end
          end
        end
        ST_CEXE: begin
          if ((req_r.req_type == REQ_TOGGLE) && in_grid) begin
            pop_r <= cur_bit ? (pop_r - PW'(1)) : (pop_r + PW'(1));
          end
        end
        ST_FETCH, ST_SHIFT, ST_SWEEP, ST_CRD, ST_RESP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_r    <= in_req.data;
          stable_r <= 1'b0;
          fetch_r  <= '0;
          up_r     <= '0;
          mid_r    <= '0;
          dn_r     <= '0;
          diff_r   <= 1'b0;
          acc_r    <= '0;
        end
      end
      ST_SHIFT: begin
        up_r  <= mid_r;
        mid_r <= dn_r;
        dn_r  <= fetch_in ? rd_data : '0;
        lft_r <= '0;
        x_r   <= '0;
        if (fetch_r == '0) begin
          fetch_r <= fetch_r + FW'(1);
        end
      end
      ST_SWEEP: begin
        up_r   <= {up_r[0], up_r[GRID_WIDTH-1:1]};
        mid_r  <= {mid_r[0], mid_r[GRID_WIDTH-1:1]};
        dn_r   <= {dn_r[0], dn_r[GRID_WIDTH-1:1]};
        lft_r  <= {up_r[0], mid_r[0], dn_r[0]};
        nrow_r <= {next_bit, nrow_r[GRID_WIDTH-1:1]};
        diff_r <= diff_r | (next_bit ^ mid_r[0]);
        acc_r  <= acc_r + PW'(next_bit);
        x_r    <= x_r + XW'(1);
        if (x_last && !fetch_end) begin
          fetch_r <= fetch_r + FW'(1);
        end
      end
      ST_COMMIT: begin
        stable_r <= !diff_r;
      end
      ST_CEXE: begin
        alive_r <= in_grid && (cur_bit ^ (req_r.req_type == REQ_TOGGLE));
      end
      ST_FETCH, ST_CRD, ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: the result transaction waits here on its own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_RESP) && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_RESP) && slot_free) begin
      rsp_r.cell_alive       <= alive_r;
      rsp_r.population       <= pop_sat;
      rsp_r.generation_count <= gen_r;
      rsp_r.stable           <= stable_r;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = rsp_r;

`ifndef SYNTHESIS
  a_sweep_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (x_r <= XW'(GRID_WIDTH - 1)))
    else $error("sweep column ran past the grid edge");

  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (32'(acc_r) <= 32'(GRID_WIDTH * GRID_HEIGHT)))
    else $error("next-grid live count exceeds the cell count");

  a_commit_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && diff_r) |=> (gen_r != '0))
    else $error("committed generation left the counter at zero");

  a_stable_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && !diff_r) |=> ($stable(gen_r) && $stable(pop_r) && stable_r))
    else $error("stable step changed the grid state");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && slot_free) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("result was not handed to the output register");
`endif

endmodule
